// ===== rtl/tccw_pkg.sv =====
// ----------------------------------------------------------------------------
// tccw_pkg: shared constants for the text console cell writer
// Field widths, operation codes, special character codes and cell defaults.
// ----------------------------------------------------------------------------
package tccw_pkg;

  // Port field widths.
  localparam int FUNC_W = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int POS_W  = 11;
  localparam int ATTR_W = 8;
  localparam int CELL_W = 16;

  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [CHAR_W-1:0] byte_t;

  // Operation codes.
  localparam func_t FN_PUT   = 2'd0;
  localparam func_t FN_CLEAR = 2'd1;
  localparam func_t FN_READ  = 2'd2;

  // Control characters and the blank cell.
  localparam byte_t CH_NEWLINE   = 8'h0A;
  localparam byte_t CH_RETURN    = 8'h0D;
  localparam byte_t CH_BACKSPACE = 8'h08;
  localparam byte_t CH_SPACE     = 8'h20;
  localparam byte_t RESET_ATTR   = 8'h07;

endpackage

// ===== rtl/tccw_ram.sv =====
// ----------------------------------------------------------------------------
// tccw_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/text_console_cell_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_cell_writer: character-cell text console engine
// Keeps a ROWS x COLS store of 16-bit cells and a cursor; puts characters,
// clears the screen, scrolls, and reads cells back.
// ----------------------------------------------------------------------------
// Usage. A command word (in_func, in_char_code, in_cell_index) is taken on a
// rising edge where start is high and busy is low. Each command produces one
// result word, shown for exactly one cycle while out_valid is high; the
// receiver cannot stall, so it must capture the word in that cycle.
// Every result carries the cursor after the command.
// Latency and throughput. A put that does not scroll, or an unused code,
// is done in the accept cycle (a printable byte is written to the store)
// and its result appears the next cycle; busy stays low, so one such
// command can be taken every cycle. A read holds busy high in S_READ
// while the memory read data returns, then shows its result. A clear, or
// a put that scrolls, walks the whole store one cell per cycle through the
// single write port of the cell memory. A scroll reads cell i+COLS and
// writes it to cell i in the next cycle, then blanks the bottom row.
// Reset. After rst_n the block runs a clearing pass that fills every cell
// with a space in attribute 7; busy is high meanwhile. The attribute
// register can be written at any time through the cfg channel, which is
// always ready.
// ----------------------------------------------------------------------------
module text_console_cell_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Command channel.
  input  logic                          start,
  output logic                          busy,
  input  logic [tccw_pkg::FUNC_W-1:0]   in_func,
  input  logic [tccw_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [tccw_pkg::IDX_W-1:0]    in_cell_index,
  // Attribute register write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tccw_pkg::ATTR_W-1:0]   cfg_data,
  // Result channel.
  output logic                          out_valid,
  output logic [tccw_pkg::ROW_W-1:0]    out_cursor_row,
  output logic [tccw_pkg::COL_W-1:0]    out_cursor_col,
  output logic [tccw_pkg::POS_W-1:0]    out_cursor_pos,
  output logic                          out_did_scroll,
  output logic [tccw_pkg::CHAR_W-1:0]   out_read_char,
  output logic [tccw_pkg::ATTR_W-1:0]   out_read_attr
);

  localparam int NCELLS = ROWS * COLS;
  localparam int AW     = $clog2(NCELLS);
  localparam int RW     = $clog2(ROWS);
  localparam int CW     = $clog2(COLS);
  localparam int COPY_N = NCELLS - COLS;
  localparam int ROW_W  = tccw_pkg::ROW_W;
  localparam int COL_W  = tccw_pkg::COL_W;
  localparam int POS_W  = tccw_pkg::POS_W;

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  // What the current sweep does to the store.
  localparam logic [1:0] K_INIT   = 2'd0;
  localparam logic [1:0] K_CLEAR  = 2'd1;
  localparam logic [1:0] K_SCROLL = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [AW-1:0] swp_r, swp_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;
  logic          pend_blank_r, pend_blank_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [7:0]    attr_r;
  logic          rd_ok_r, rd_ok_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          did_scroll_r, did_scroll_nxt;
  logic [7:0]    read_char_r, read_char_nxt;
  logic [7:0]    read_attr_r, read_attr_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  tccw_pkg::cell_t ram_wdata;
  tccw_pkg::cell_t ram_rdata;

  logic [7:0]    blank_attr;
  logic          row_last;
  logic          col_last;
  logic          copy_step;
  logic [AW-1:0] pos_next_row;

  tccw_ram #(
    .WIDTH(tccw_pkg::CELL_W),
    .DEPTH(NCELLS)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // The reset pass always blanks with the power-on attribute; clears and
  // scrolls use whatever attribute is programmed at that moment.
  assign blank_attr   = (kind_r == K_INIT) ? tccw_pkg::RESET_ATTR : attr_r;
  assign row_last     = (row_r == RW'(ROWS - 1));
  assign col_last     = (col_r == CW'(COLS - 1));
  assign copy_step    = (kind_r == K_SCROLL) && (swp_r < AW'(COPY_N));
  // Linear position of column 0 on the next row, kept without a multiplier.
  assign pos_next_row = pos_r - AW'(col_r) + AW'(COLS);

  always_comb begin
    logic adv_row;
    adv_row        = 1'b0;
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    swp_nxt        = swp_r;
    pend_nxt       = 1'b0;
    pend_addr_nxt  = pend_addr_r;
    pend_blank_nxt = pend_blank_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    pos_nxt        = pos_r;
    rd_ok_nxt      = rd_ok_r;
    out_valid_nxt  = 1'b0;
    did_scroll_nxt = did_scroll_r;
    read_char_nxt  = read_char_r;
    read_attr_nxt  = read_attr_r;
    ram_we         = 1'b0;
    ram_waddr      = pend_addr_r;
    ram_wdata      = pend_blank_r ? {blank_attr, tccw_pkg::CH_SPACE} : ram_rdata;
    ram_raddr      = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_func)
            tccw_pkg::FN_PUT: begin
              did_scroll_nxt = 1'b0;
              read_char_nxt  = '0;
              read_attr_nxt  = '0;
              if (in_char_code == tccw_pkg::CH_NEWLINE) begin
                col_nxt = '0;
                adv_row = 1'b1;
              end else if (in_char_code == tccw_pkg::CH_RETURN) begin
                col_nxt = '0;
                pos_nxt = pos_r - AW'(col_r);
              end else if (in_char_code == tccw_pkg::CH_BACKSPACE) begin
                if (col_r != '0) begin
                  col_nxt = col_r - 1'b1;
                  pos_nxt = pos_r - 1'b1;
                end
              end else begin
                ram_we    = 1'b1;
                ram_waddr = pos_r;
                ram_wdata = {attr_r, in_char_code};
                if (col_last) begin
                  col_nxt = '0;
                  adv_row = 1'b1;
                end else begin
                  col_nxt = col_r + 1'b1;
                  pos_nxt = pos_r + 1'b1;
                end
              end
              if (adv_row && row_last) begin
                // Cursor ends at column 0 of the bottom row after the scroll.
                pos_nxt   = AW'(COPY_N);
                kind_nxt  = K_SCROLL;
                swp_nxt   = '0;
                state_nxt = S_SWEEP;
              end else begin
                if (adv_row) begin
                  row_nxt = row_r + 1'b1;
                  pos_nxt = pos_next_row;
                end
                out_valid_nxt = 1'b1;
              end
            end
            tccw_pkg::FN_CLEAR: begin
              row_nxt   = '0;
              col_nxt   = '0;
              pos_nxt   = '0;
              kind_nxt  = K_CLEAR;
              swp_nxt   = '0;
              state_nxt = S_SWEEP;
            end
            tccw_pkg::FN_READ: begin
              ram_raddr = AW'(in_cell_index);
              rd_ok_nxt = (32'(in_cell_index) < 32'(NCELLS));
              state_nxt = S_READ;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              did_scroll_nxt = 1'b0;
              read_char_nxt  = '0;
              read_attr_nxt  = '0;
            end
          endcase
        end
      end
      S_READ: begin
        out_valid_nxt  = 1'b1;
        did_scroll_nxt = 1'b0;
        read_char_nxt  = rd_ok_r ? ram_rdata[7:0] : '0;
        read_attr_nxt  = rd_ok_r ? ram_rdata[15:8] : '0;
        state_nxt      = S_IDLE;
      end
      S_SWEEP: begin
        // Write the cell issued last cycle; issue this cycle's cell.
        ram_we         = pend_r;
        pend_nxt       = 1'b1;
        pend_addr_nxt  = swp_r;
        pend_blank_nxt = !copy_step;
        if (copy_step) begin
          ram_raddr = swp_r + AW'(COLS);
        end
        if (swp_r == AW'(NCELLS - 1)) begin
          state_nxt = S_DRAIN;
        end else begin
          swp_nxt = swp_r + 1'b1;
        end
      end
      S_DRAIN: begin
        ram_we    = pend_r;
        state_nxt = S_IDLE;
        if (kind_r != K_INIT) begin
          out_valid_nxt  = 1'b1;
          did_scroll_nxt = (kind_r == K_SCROLL);
          read_char_nxt  = '0;
          read_attr_nxt  = '0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      kind_r      <= K_INIT;
      swp_r       <= '0;
      pend_r      <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      pos_r       <= '0;
      attr_r      <= tccw_pkg::RESET_ATTR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      swp_r       <= swp_nxt;
      pend_r      <= pend_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        attr_r <= cfg_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pend_addr_r  <= pend_addr_nxt;
    pend_blank_r <= pend_blank_nxt;
    rd_ok_r      <= rd_ok_nxt;
    did_scroll_r <= did_scroll_nxt;
    read_char_r  <= read_char_nxt;
    read_attr_r  <= read_attr_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_cursor_row = ROW_W'(row_r);
  assign out_cursor_col = COL_W'(col_r);
  assign out_cursor_pos = POS_W'(pos_r);
  assign out_did_scroll = did_scroll_r;
  assign out_read_char  = read_char_r;
  assign out_read_attr  = read_attr_r;

`ifndef SYNTH
  // The incrementally kept position always matches row * COLS + col.
  a_pos_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    int'(pos_r) == int'(row_r) * COLS + int'(col_r))
    else $error("cursor position out of step with row and column");

  // The cursor column never reaches COLS.
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(col_r) < COLS)
    else $error("cursor column out of range");

  // A result is only shown once the sequencer is back in idle.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result shown while busy");

  // A scroll always leaves the cursor at column 0 of the bottom row.
  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && did_scroll_r) |-> (row_last && (col_r == '0)))
    else $error("scroll left cursor off the bottom row start");
`endif

endmodule

// ===== dv/text_console_cell_writer_tb.sv =====
// ----------------------------------------------------------------------------
// text_console_cell_writer_tb: self-checking bench for the text console
// Drives put, clear, read and unused commands into the console, keeps its own
// model of the cell store and cursor, and checks every result word field by
// field. Directed cases come first, then random text traffic in several
// idling phases with the attribute register changed between phases.
// ----------------------------------------------------------------------------
module text_console_cell_writer_tb;
  import tccw_pkg::*;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int NCELLS = COLS * ROWS;

  // The code that the console must ignore apart from reporting the cursor.
  localparam func_t FN_UNUSED = 2'd3;

  // A clear or a scroll walks the whole store with no traffic on any channel,
  // which is normal. The limit leaves a wide margin over such a walk.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int MAX_REPORTED   = 10;

  // One result word as the console reports it.
  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [POS_W-1:0]  cursor_pos;
    logic              did_scroll;
    byte_t             read_char;
    logic [ATTR_W-1:0] read_attr;
  } cursor_report_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [FUNC_W-1:0] in_func;
  logic [CHAR_W-1:0] in_char_code;
  logic [IDX_W-1:0]  in_cell_index;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [ATTR_W-1:0] cfg_data;
  logic              out_valid;
  logic [ROW_W-1:0]  out_cursor_row;
  logic [COL_W-1:0]  out_cursor_col;
  logic [POS_W-1:0]  out_cursor_pos;
  logic              out_did_scroll;
  logic [CHAR_W-1:0] out_read_char;
  logic [ATTR_W-1:0] out_read_attr;

  text_console_cell_writer #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_char_code  (in_char_code),
    .in_cell_index (in_cell_index),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_cursor_row(out_cursor_row),
    .out_cursor_col(out_cursor_col),
    .out_cursor_pos(out_cursor_pos),
    .out_did_scroll(out_did_scroll),
    .out_read_char (out_read_char),
    .out_read_attr (out_read_attr)
  );

  // Model of the console: its own cell store, cursor and attribute register.
  logic [CELL_W-1:0] screen_model [NCELLS];
  int unsigned       row_model;
  int unsigned       col_model;
  byte_t             attr_model;

  // Result words still owed by the console, oldest first.
  cursor_report_t cursor_reports_due[$];

  int unsigned mismatch_count;
  int unsigned sender_idle_pct;
  int unsigned quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one command to the model and returns the word the console owes.
  // Control characters move the cursor without touching the store; any other
  // byte is written at the cursor. Passing the bottom row scrolls the store up
  // one row and blanks the new bottom row in the current attribute.
  function automatic cursor_report_t apply_console_command(input func_t f, input byte_t ch,
                                                           input logic [IDX_W-1:0] idx);
    cursor_report_t    rep;
    logic [CELL_W-1:0] blank;
    int unsigned       i;
    rep   = '0;
    blank = {attr_model, CH_SPACE};
    case (f)
      FN_PUT: begin
        if (ch == CH_NEWLINE) begin
          col_model = 0;
          row_model++;
        end else if (ch == CH_RETURN) begin
          col_model = 0;
        end else if (ch == CH_BACKSPACE) begin
          // Backspace stops at the left edge and leaves the cell as it is.
          if (col_model > 0) col_model--;
        end else begin
          screen_model[row_model * COLS + col_model] = {attr_model, ch};
          col_model++;
          if (col_model >= COLS) begin
            col_model = 0;
            row_model++;
          end
        end
        if (row_model >= ROWS) begin
          for (i = COLS; i < NCELLS; i++) screen_model[i - COLS] = screen_model[i];
          for (i = NCELLS - COLS; i < NCELLS; i++) screen_model[i] = blank;
          row_model      = ROWS - 1;
          rep.did_scroll = 1'b1;
        end
      end
      FN_CLEAR: begin
        for (i = 0; i < NCELLS; i++) screen_model[i] = blank;
        row_model = 0;
        col_model = 0;
      end
      FN_READ: begin
        // Addresses past the store read as zero.
        if (idx < NCELLS) begin
          rep.read_char = screen_model[idx][7:0];
          rep.read_attr = screen_model[idx][15:8];
        end
      end
      default: begin
      end
    endcase
    rep.cursor_row = row_model[ROW_W-1:0];
    rep.cursor_col = col_model[COL_W-1:0];
    rep.cursor_pos = POS_W'(row_model * COLS + col_model);
    return rep;
  endfunction

  // Sends one command word. Called at a rising edge; start changes at most once
  // per edge, and it stays high between back-to-back words.
  task automatic send_command(input func_t f, input byte_t ch, input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_func       <= f;
    in_char_code  <= ch;
    in_cell_index <= idx;
    do @(posedge clk); while (busy !== 1'b0);
    cursor_reports_due.push_back(apply_console_command(f, ch, idx));
  endtask

  // Lowers start and waits until every owed word has come back and the
  // console has dropped busy, then lets it settle before returning.
  task automatic wait_for_drain();
    start <= 1'b0;
    while (cursor_reports_due.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the attribute register while the console is idle. The model takes
  // the new value at the same edge as the console.
  task automatic set_text_attribute(input byte_t value);
    wait_for_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    attr_model = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic flag_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTED)
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  // Every result word is taken in the one cycle it is shown and compared
  // with the oldest word the model owes.
  always @(posedge clk) begin : check_results
    cursor_report_t want;
    if (rst_n && out_valid) begin
      if (cursor_reports_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED)
          $display("result word with no command outstanding, cursor_pos %0d", out_cursor_pos);
      end else begin
        want = cursor_reports_due.pop_front();
        if (out_cursor_row !== want.cursor_row)
          flag_mismatch("cursor_row", want.cursor_row, out_cursor_row);
        if (out_cursor_col !== want.cursor_col)
          flag_mismatch("cursor_col", want.cursor_col, out_cursor_col);
        if (out_cursor_pos !== want.cursor_pos)
          flag_mismatch("cursor_pos", want.cursor_pos, out_cursor_pos);
        if (out_did_scroll !== want.did_scroll)
          flag_mismatch("did_scroll", want.did_scroll, out_did_scroll);
        if (out_read_char !== want.read_char)
          flag_mismatch("read_char", want.read_char, out_read_char);
        if (out_read_attr !== want.read_attr)
          flag_mismatch("read_attr", want.read_attr, out_read_attr);
      end
    end
  end

  // Ends the run when nothing moves on any channel for too long. Any word
  // accepted or shown restarts the count.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // After reset the console runs its own clearing pass, so every cell must
  // read as a blank in attribute 7. The addresses cover both ends of the
  // store, the first address past it, the top of the address range, and
  // alternating bit patterns.
  task automatic test_reset_contents();
    send_command(FN_READ, 8'h00, 11'd0);
    send_command(FN_READ, 8'hFF, 11'd1999);
    send_command(FN_READ, 8'h00, 11'd2000);
    send_command(FN_READ, 8'hFF, 11'd2047);
    send_command(FN_READ, 8'h55, 11'h555);
    send_command(FN_READ, 8'hAA, 11'h2AA);
  endtask

  // Character extremes, each control character, the unused code and a clear.
  task automatic test_command_basics();
    send_command(FN_PUT, 8'h00, 11'd0);
    send_command(FN_PUT, 8'hFF, 11'd2047);
    send_command(FN_PUT, 8'h41, 11'd0);
    // Backspace steps back over the 'A' without erasing it.
    send_command(FN_PUT, CH_BACKSPACE, 11'd0);
    send_command(FN_PUT, 8'h7F, 11'd0);
    send_command(FN_PUT, CH_RETURN, 11'd0);
    // Backspace at the left edge keeps the cursor in column 0.
    send_command(FN_PUT, CH_BACKSPACE, 11'd0);
    send_command(FN_READ, 8'h00, 11'd0);
    send_command(FN_READ, 8'h00, 11'd1);
    send_command(FN_READ, 8'h00, 11'd2);
    send_command(FN_UNUSED, 8'hFF, 11'd2047);
    send_command(FN_PUT, CH_NEWLINE, 11'd0);
    send_command(FN_PUT, 8'h5A, 11'd0);
    send_command(FN_READ, 8'h00, 11'd80);
    send_command(FN_CLEAR, 8'hFF, 11'd2047);
    send_command(FN_READ, 8'h00, 11'd0);
    send_command(FN_READ, 8'h00, 11'd80);
  endtask

  // Walks the cursor down to the bottom row and past it, so the store scrolls
  // and the bottom row is refilled in a non-default attribute.
  task automatic test_scroll_walk();
    set_text_attribute(8'hA5);
    send_command(FN_PUT, 8'h23, 11'd0);
    repeat (ROWS - 1) send_command(FN_PUT, CH_NEWLINE, 11'd0);
    send_command(FN_PUT, 8'h51, 11'd0);
    send_command(FN_PUT, CH_NEWLINE, 11'd0);
    send_command(FN_READ, 8'h00, 11'd0);
    send_command(FN_READ, 8'h00, 11'(NCELLS - 2 * COLS));
    send_command(FN_READ, 8'h00, 11'(NCELLS - COLS));
  endtask

  // Random text traffic. Most of it is runs of printable text, long enough
  // now and then to wrap, with newlines that carry the cursor to the bottom
  // row and keep scrolling there. Reads look mostly around the cursor, where
  // the store has just been written. Clears are rare because each one walks
  // the whole store; raw bytes and the unused code make up the noise.
  task automatic run_console_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned run_len;
    int          addr;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        run_len = ($urandom_range(9) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 30);
        repeat (run_len)
          send_command(FN_PUT,
                       ($urandom_range(99) < 85) ? byte_t'($urandom_range(32, 126))
                                                 : byte_t'($urandom_range(255)),
                       IDX_W'($urandom_range(2047)));
        sent += run_len;
        if ($urandom_range(1)) begin
          send_command(FN_PUT, CH_NEWLINE, IDX_W'($urandom_range(2047)));
          sent++;
        end
      end else if (pick < 55) begin
        send_command(FN_PUT, CH_NEWLINE, IDX_W'($urandom_range(2047)));
        sent++;
      end else if (pick < 60) begin
        run_len = $urandom_range(1, 4);
        repeat (run_len)
          send_command(FN_PUT, $urandom_range(1) ? CH_BACKSPACE : CH_RETURN,
                       IDX_W'($urandom_range(2047)));
        sent += run_len;
      end else if (pick < 82) begin
        run_len = $urandom_range(1, 6);
        repeat (run_len) begin
          case ($urandom_range(9))
            0: addr = $urandom_range(2047, NCELLS);
            1, 2: addr = $urandom_range(NCELLS - 1);
            default: begin
              addr = int'(row_model * COLS + col_model) - int'($urandom_range(COLS));
              if (addr < 0) addr = 0;
            end
          endcase
          send_command(FN_READ, byte_t'($urandom_range(255)), IDX_W'(addr));
        end
        sent += run_len;
      end else if (pick < 83) begin
        send_command(FN_CLEAR, byte_t'($urandom_range(255)), IDX_W'($urandom_range(2047)));
        sent++;
      end else if (pick < 88) begin
        send_command(FN_UNUSED, byte_t'($urandom_range(255)), IDX_W'($urandom_range(2047)));
        sent++;
      end else begin
        send_command(FN_PUT, byte_t'($urandom_range(255)), IDX_W'($urandom_range(2047)));
        sent++;
      end
    end
  endtask

  // Four phases of random traffic: no gaps, a mostly idle sender, a lightly
  // idle sender, and no gaps again. The attribute changes between phases and
  // covers both extremes.
  task automatic test_random_traffic();
    set_text_attribute(8'h00);
    sender_idle_pct = 0;
    run_console_traffic(480);
    set_text_attribute(8'hFF);
    sender_idle_pct = 66;
    run_console_traffic(480);
    set_text_attribute(byte_t'($urandom_range(255)));
    sender_idle_pct = 27;
    run_console_traffic(480);
    set_text_attribute(8'h1E);
    sender_idle_pct = 0;
    run_console_traffic(480);
  endtask

  initial begin : stimulus
    int unsigned i;
    start          <= 1'b0;
    in_func        <= FN_PUT;
    in_char_code   <= 8'h00;
    in_cell_index  <= '0;
    cfg_valid      <= 1'b0;
    cfg_data       <= RESET_ATTR;
    rst_n          <= 1'b0;
    mismatch_count  = 0;
    sender_idle_pct = 0;
    quiet_cycles    = 0;

    // The model starts where the console lands after its clearing pass.
    attr_model = RESET_ATTR;
    for (i = 0; i < NCELLS; i++) screen_model[i] = {RESET_ATTR, CH_SPACE};
    row_model = 0;
    col_model = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_contents();
    test_command_basics();
    test_scroll_walk();
    test_random_traffic();

    wait_for_drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tccw_pkg.sv
rtl/tccw_ram.sv
rtl/text_console_cell_writer.sv
dv/text_console_cell_writer_tb.sv
